// ===== src/wstk_pkg.sv =====
// Shared types, constants and codes for the weighted score top-k block.
package wstk_pkg;

  localparam int NUM_FEATURES_DEF = 7;
  localparam int MAX_SLOTS        = 7;
  localparam int NUM_REGS         = 8;
  localparam int IDX_W            = 3;
  localparam int CFG_IDX_W        = 4;
  localparam int Q_W              = 16;
  localparam int PROD_W           = 32;
  localparam int ACC_W            = 36;

  localparam logic [IDX_W-1:0] OVL_IDX = 3'd7;

  localparam logic signed [ACC_W-1:0] ONE_Q30 = 36'sh0_4000_0000;
  localparam logic [Q_W-1:0]          ONE_Q15 = 16'h8000;

  localparam logic [Q_W-1:0] W_RESET [NUM_REGS] = '{
    16'd9830, 16'd8192, 16'd3277, 16'd2621, 16'd3277, 16'd1638, 16'd3932, 16'd3277
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_START,
    ST_SCAN,
    ST_SWAP,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    SOP_NONE,
    SOP_LOAD,
    SOP_START,
    SOP_SCAN,
    SOP_SWAP
  } sort_op_t;

  typedef struct packed {
    logic             clr;
    logic             vld;
    logic             sub;
    logic [IDX_W-1:0] idx;
  } mac_ctl_t;

  typedef struct packed {
    logic              load;
    logic [IDX_W-1:0]  idx;
    logic [PROD_W-1:0] prod;
  } mac_st_t;

  typedef struct packed {
    sort_op_t         op;
    logic [IDX_W-1:0] addr;
  } sort_ctl_t;

  typedef struct packed {
    logic [PROD_W-1:0] rd_prod;
    logic [IDX_W-1:0]  rd_id;
    logic              best_zero;
  } sort_st_t;

endpackage

// ===== src/wstk_mac.sv =====
// Shared multiplier with a registered product and a signed accumulator.
module wstk_mac (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  wstk_pkg::mac_ctl_t                    ctl,
  input  logic [wstk_pkg::Q_W-1:0]              weight,
  input  logic [wstk_pkg::Q_W-1:0]              feat,
  output wstk_pkg::mac_st_t                     st,
  output logic [wstk_pkg::Q_W-1:0]              score
);

  logic [wstk_pkg::PROD_W-1:0]        prod_r;
  logic                               vld_r;
  logic                               sub_r;
  logic [wstk_pkg::IDX_W-1:0]         idx_r;
  logic signed [wstk_pkg::ACC_W-1:0]  acc_r;
  logic signed [wstk_pkg::ACC_W-1:0]  prod_ext;

  assign prod_ext = signed'({{(wstk_pkg::ACC_W - wstk_pkg::PROD_W){1'b0}}, prod_r});

  // Stage one: multiply.
  always_ff @(posedge clk) begin
    prod_r <= wstk_pkg::PROD_W'(weight) * wstk_pkg::PROD_W'(feat);
    idx_r  <= ctl.idx;
    sub_r  <= ctl.sub;
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctl.vld;
    end
  end

  // Stage two: add feature terms, subtract the penalty term.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.clr) begin
      acc_r <= '0;
    end else if (vld_r) begin
      acc_r <= sub_r ? (acc_r - prod_ext) : (acc_r + prod_ext);
    end
  end

  assign st.load = vld_r && !sub_r;
  assign st.idx  = idx_r;
  assign st.prod = prod_r;

  // Clamp to [0, 1.0] and keep bits 30..15.
  always_comb begin
    if (acc_r[wstk_pkg::ACC_W-1]) begin
      score = '0;
    end else if (acc_r > wstk_pkg::ONE_Q30) begin
      score = wstk_pkg::ONE_Q15;
    end else begin
      score = acc_r[30:15];
    end
  end

endmodule

// ===== src/wstk_sort.sv =====
// Slot store and single-compare unit for the swap-based selection sort.
module wstk_sort (
  input  logic                          clk,
  input  wstk_pkg::sort_ctl_t           ctl,
  input  logic [wstk_pkg::PROD_W-1:0]   wr_prod,
  output wstk_pkg::sort_st_t            st
);

  logic [wstk_pkg::PROD_W-1:0] prod_r [wstk_pkg::MAX_SLOTS];
  logic [wstk_pkg::IDX_W-1:0]  id_r   [wstk_pkg::MAX_SLOTS];
  logic [wstk_pkg::PROD_W-1:0] best_val_r;
  logic [wstk_pkg::IDX_W-1:0]  best_id_r;
  logic [wstk_pkg::IDX_W-1:0]  best_idx_r;
  logic [wstk_pkg::PROD_W-1:0] cur_val_r;
  logic [wstk_pkg::IDX_W-1:0]  cur_id_r;
  logic [wstk_pkg::PROD_W-1:0] rd_prod;
  logic [wstk_pkg::IDX_W-1:0]  rd_id;

  // One read address per cycle.
  assign rd_prod = prod_r[ctl.addr];
  assign rd_id   = id_r[ctl.addr];

  always_ff @(posedge clk) begin
    case (ctl.op)
      wstk_pkg::SOP_LOAD: begin
        prod_r[ctl.addr] <= wr_prod;
        id_r[ctl.addr]   <= ctl.addr;
      end
      wstk_pkg::SOP_START: begin
        best_val_r <= rd_prod;
        best_id_r  <= rd_id;
        best_idx_r <= ctl.addr;
        cur_val_r  <= rd_prod;
        cur_id_r   <= rd_id;
      end
      wstk_pkg::SOP_SCAN: begin
        if (rd_prod > best_val_r) begin
          best_val_r <= rd_prod;
          best_id_r  <= rd_id;
          best_idx_r <= ctl.addr;
        end
      end
      wstk_pkg::SOP_SWAP: begin
        // Move the old slot contents only when the pick came from elsewhere.
        if (best_idx_r != ctl.addr) begin
          prod_r[ctl.addr]   <= best_val_r;
          id_r[ctl.addr]     <= best_id_r;
          prod_r[best_idx_r] <= cur_val_r;
          id_r[best_idx_r]   <= cur_id_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign st.rd_prod   = rd_prod;
  assign st.rd_id     = rd_id;
  assign st.best_zero = (best_val_r == '0);

endmodule

// ===== src/weighted_score_topk_reasons.sv =====
// Top level: weighted linear score with top-k reason selection.
// Each accepted beat carries seven Q1.15 feature scores, an overload penalty
// and a reason limit. One shared 16x16 multiplier runs under a small
// sequencer: it issues NSLOT+1 products (NSLOT = NUM_FEATURES capped at 7),
// one per cycle, into a registered accumulator, then passes through a drain
// state. The clamped Q1.15 score comes from the accumulator. A selection
// sort then runs over the slot store with one comparator: pass i is a start
// read, NSLOT-1-i compares and one swap, and the sort stops at the limit or
// at the first pick whose product is zero. Results leave one beat per cycle
// while the output is not stalled, through an output register, one beat per
// reason, or a single empty beat with last set. in_stall is high from accept
// until the last result is loaded into the output register; a finished
// result may still wait there while the next beat is taken. Weights are
// written through cfg_* at any time the block is idle; writes to indexes
// beyond 7 are dropped.
module weighted_score_topk_reasons #(
  parameter int NUM_FEATURES = wstk_pkg::NUM_FEATURES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [wstk_pkg::Q_W-1:0]          in_feat_type,
  input  logic [wstk_pkg::Q_W-1:0]          in_feat_event,
  input  logic [wstk_pkg::Q_W-1:0]          in_feat_name,
  input  logic [wstk_pkg::Q_W-1:0]          in_feat_spatial,
  input  logic [wstk_pkg::Q_W-1:0]          in_feat_layer,
  input  logic [wstk_pkg::Q_W-1:0]          in_feat_parent,
  input  logic [wstk_pkg::Q_W-1:0]          in_feat_recency,
  input  logic [wstk_pkg::Q_W-1:0]          in_feat_overload,
  input  logic [2:0]                        in_max_reasons,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [wstk_pkg::Q_W-1:0]          out_score,
  output logic                              out_reason_valid,
  output logic [wstk_pkg::IDX_W-1:0]        out_reason_id,
  output logic [wstk_pkg::Q_W-1:0]          out_contribution,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wstk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wstk_pkg::Q_W-1:0]          cfg_data
);

  localparam int NSLOT = (NUM_FEATURES < wstk_pkg::MAX_SLOTS) ?
                         NUM_FEATURES : wstk_pkg::MAX_SLOTS;
  localparam logic [wstk_pkg::IDX_W-1:0] NSLOT_C   = wstk_pkg::IDX_W'(NSLOT);
  localparam logic [wstk_pkg::IDX_W-1:0] LAST_SLOT = wstk_pkg::IDX_W'(NSLOT - 1);

  wstk_pkg::state_t                 state_r, state_nxt;
  logic [wstk_pkg::Q_W-1:0]         w_r    [wstk_pkg::NUM_REGS];
  logic [wstk_pkg::Q_W-1:0]         feat_r [wstk_pkg::NUM_REGS];
  logic [wstk_pkg::IDX_W-1:0]       take_r, take_nxt;
  logic [wstk_pkg::IDX_W-1:0]       mac_idx_r, mac_idx_nxt;
  logic [wstk_pkg::IDX_W-1:0]       pass_r, pass_nxt;
  logic [wstk_pkg::IDX_W-1:0]       scan_r, scan_nxt;
  logic [wstk_pkg::IDX_W-1:0]       count_r, count_nxt;
  logic [wstk_pkg::IDX_W-1:0]       emit_r, emit_nxt;

  logic                             out_valid_r;
  logic [wstk_pkg::Q_W-1:0]         out_score_r;
  logic                             out_reason_valid_r;
  logic [wstk_pkg::IDX_W-1:0]       out_reason_id_r;
  logic [wstk_pkg::Q_W-1:0]         out_contribution_r;
  logic                             out_last_r;

  logic                             in_acc;
  logic                             cfg_wr;
  logic                             out_free;
  logic                             out_load;
  logic                             emit_last;
  logic [wstk_pkg::IDX_W-1:0]       take_in;
  logic [wstk_pkg::Q_W:0]           contrib_raw;
  logic [wstk_pkg::Q_W-1:0]         contrib_sat;
  logic [wstk_pkg::Q_W-1:0]         score;

  wstk_pkg::mac_ctl_t               mac_ctl;
  wstk_pkg::mac_st_t                mac_st;
  wstk_pkg::sort_ctl_t              seq_sort_ctl;
  wstk_pkg::sort_ctl_t              sort_ctl;
  wstk_pkg::sort_st_t               sort_st;

  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;
  assign take_in   = (in_max_reasons > NSLOT_C) ? NSLOT_C : in_max_reasons;
  assign emit_last = (count_r == '0) || ((emit_r + 3'd1) == count_r);

  // Saturate the shifted product to 16 bits.
  assign contrib_raw = sort_st.rd_prod[wstk_pkg::PROD_W-1:15];
  assign contrib_sat = contrib_raw[wstk_pkg::Q_W] ? '1 : contrib_raw[wstk_pkg::Q_W-1:0];

  // Weight registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < wstk_pkg::NUM_REGS; k++) begin
        w_r[k] <= wstk_pkg::W_RESET[k];
      end
    end else if (cfg_wr && (cfg_index < wstk_pkg::CFG_IDX_W'(wstk_pkg::NUM_REGS))) begin
      w_r[cfg_index[wstk_pkg::IDX_W-1:0]] <= cfg_data;
    end
  end

  // Hold the accepted beat's features for the multiply sweep.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      feat_r[0] <= in_feat_type;
      feat_r[1] <= in_feat_event;
      feat_r[2] <= in_feat_name;
      feat_r[3] <= in_feat_spatial;
      feat_r[4] <= in_feat_layer;
      feat_r[5] <= in_feat_parent;
      feat_r[6] <= in_feat_recency;
      feat_r[7] <= in_feat_overload;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wstk_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = wstk_pkg::ST_MAC;
      end
      wstk_pkg::ST_MAC: begin
        if (mac_idx_r == wstk_pkg::OVL_IDX) state_nxt = wstk_pkg::ST_DRAIN;
      end
      wstk_pkg::ST_DRAIN: begin
        state_nxt = (take_r == '0) ? wstk_pkg::ST_EMIT : wstk_pkg::ST_START;
      end
      wstk_pkg::ST_START: begin
        state_nxt = (pass_r == LAST_SLOT) ? wstk_pkg::ST_SWAP : wstk_pkg::ST_SCAN;
      end
      wstk_pkg::ST_SCAN: begin
        if (scan_r == LAST_SLOT) state_nxt = wstk_pkg::ST_SWAP;
      end
      wstk_pkg::ST_SWAP: begin
        if (sort_st.best_zero || ((pass_r + 3'd1) == take_r)) begin
          state_nxt = wstk_pkg::ST_EMIT;
        end else begin
          state_nxt = wstk_pkg::ST_START;
        end
      end
      wstk_pkg::ST_EMIT: begin
        if (out_free && emit_last) state_nxt = wstk_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = wstk_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs and counters.
  always_comb begin
    in_stall     = 1'b1;
    take_nxt     = take_r;
    mac_idx_nxt  = mac_idx_r;
    pass_nxt     = pass_r;
    scan_nxt     = scan_r;
    count_nxt    = count_r;
    emit_nxt     = emit_r;
    mac_ctl      = '0;
    seq_sort_ctl = '{op: wstk_pkg::SOP_NONE, addr: '0};
    out_load     = 1'b0;
    case (state_r)
      wstk_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_acc) begin
          take_nxt    = take_in;
          mac_idx_nxt = '0;
          mac_ctl.clr = 1'b1;
        end
      end
      wstk_pkg::ST_MAC: begin
        mac_ctl.vld = 1'b1;
        mac_ctl.idx = mac_idx_r;
        mac_ctl.sub = (mac_idx_r == wstk_pkg::OVL_IDX);
        mac_idx_nxt = (mac_idx_r == LAST_SLOT) ? wstk_pkg::OVL_IDX : mac_idx_r + 3'd1;
      end
      wstk_pkg::ST_DRAIN: begin
        pass_nxt  = '0;
        count_nxt = '0;
        emit_nxt  = '0;
      end
      wstk_pkg::ST_START: begin
        seq_sort_ctl = '{op: wstk_pkg::SOP_START, addr: pass_r};
        scan_nxt     = pass_r + 3'd1;
      end
      wstk_pkg::ST_SCAN: begin
        seq_sort_ctl = '{op: wstk_pkg::SOP_SCAN, addr: scan_r};
        scan_nxt     = scan_r + 3'd1;
      end
      wstk_pkg::ST_SWAP: begin
        seq_sort_ctl = '{op: wstk_pkg::SOP_SWAP, addr: pass_r};
        count_nxt    = sort_st.best_zero ? pass_r : pass_r + 3'd1;
        pass_nxt     = pass_r + 3'd1;
        emit_nxt     = '0;
      end
      wstk_pkg::ST_EMIT: begin
        seq_sort_ctl = '{op: wstk_pkg::SOP_NONE, addr: emit_r};
        if (out_free) begin
          out_load = 1'b1;
          emit_nxt = emit_r + 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Product loads from the multiplier take the store during the sweep.
  always_comb begin
    if (mac_st.load) begin
      sort_ctl = '{op: wstk_pkg::SOP_LOAD, addr: mac_st.idx};
    end else begin
      sort_ctl = seq_sort_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wstk_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    take_r    <= take_nxt;
    mac_idx_r <= mac_idx_nxt;
    pass_r    <= pass_nxt;
    scan_r    <= scan_nxt;
    count_r   <= count_nxt;
    emit_r    <= emit_nxt;
  end

  // Output register: load a result, drop valid once the beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_score_r <= score;
      out_last_r  <= emit_last;
      if (count_r == '0) begin
        out_reason_valid_r <= 1'b0;
        out_reason_id_r    <= '0;
        out_contribution_r <= '0;
      end else begin
        out_reason_valid_r <= 1'b1;
        out_reason_id_r    <= sort_st.rd_id;
        out_contribution_r <= contrib_sat;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_score        = out_score_r;
  assign out_reason_valid = out_reason_valid_r;
  assign out_reason_id    = out_reason_id_r;
  assign out_contribution = out_contribution_r;
  assign out_last         = out_last_r;

  wstk_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .weight (w_r[mac_ctl.idx]),
    .feat   (feat_r[mac_ctl.idx]),
    .st     (mac_st),
    .score  (score)
  );

  wstk_sort u_sort (
    .clk     (clk),
    .ctl     (sort_ctl),
    .wr_prod (mac_st.prod),
    .st      (sort_st)
  );

`ifndef NO_ASSERTIONS
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_reason_valid) |-> out_last)
    else $error("empty result beat without last");

  a_score_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_score <= wstk_pkg::ONE_Q15))
    else $error("score above 1.0");

  a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wstk_pkg::ST_EMIT) |-> (count_r <= take_r))
    else $error("more reasons than the limit");

  a_accept_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == wstk_pkg::ST_MAC))
    else $error("accepted beat did not start the multiply sweep");
`endif

endmodule
